### design/pid_speed_slew_limiter_assert.svh
// Assertion macros used by the speed slew limiter top level.
`ifndef PID_SPEED_SLEW_LIMITER_ASSERT_SVH
`define PID_SPEED_SLEW_LIMITER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### design/pssl_pkg.sv
// Shared types and constants of the speed slew limiter.
`default_nettype none
package pssl_pkg;

   localparam int GAIN_WIDTH  = 24;
   localparam int LIMIT_WIDTH = 31;
   localparam int VEL_WIDTH   = LIMIT_WIDTH + 1;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = LIMIT_WIDTH;

   // Register indexes of the configuration port
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_KP_GAIN       = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_KI_TIMES_STEP = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_KD_OVER_STEP  = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SPEED_LIMIT   = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ACCEL_STEP    = 3'd4;

   localparam logic [LIMIT_WIDTH-1:0] ACCEL_STEP_RESET = 31'd66;

   // Command into the serial multiply-accumulate unit
   typedef struct packed {
      logic start;
      logic clear;
   } mac_ctrl_type;

   // Status out of the serial multiply-accumulate unit
   typedef struct packed {
      logic busy;
      logic done;
   } mac_stat_type;

endpackage
`default_nettype wire

### design/pid_speed_slew_limiter.sv
// PID speed controller with slew-rate limit: top level.
//
// Input channel req_*: one position offset (offset_x, offset_y, signed fixed
// point) per control tick, valid/ready. Result channel rsp_*: one velocity per
// accepted offset, valid/ready. Configuration port csr_*: one register write
// per cycle with csr_wr_en high; write only while no tick is in flight.
//
// Each tick runs on shared bit-serial hardware: the serial multiplier forms
// x*x and y*y, the digit-serial root unit forms the square root, then the
// multiplier forms the P, D and I products, and the slew stage caps, slews
// and clamps the result. One tick is in flight at a time; the next offset is
// accepted the cycle after a result is placed in the output register, so a
// new offset is not taken before the last tick is through.
//
// Reset clears gains and limits to their defaults, the error sum, the last
// error and the last velocity. When the receiver stalls, the result waits in
// the output register, a new tick may still be accepted, and that tick holds
// before its result is written until the register is free.
`default_nettype none
module pid_speed_slew_limiter #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int SUM_WIDTH  = 48
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output      logic                                       req_ready,
   input  wire logic signed [DATA_WIDTH-1:0]               req_offset_x,
   input  wire logic signed [DATA_WIDTH-1:0]               req_offset_y,
   output      logic                                       rsp_valid,
   input  wire logic                                       rsp_ready,
   output      logic signed [DATA_WIDTH-1:0]               rsp_velocity,
   input  wire logic                                       csr_wr_en,
   input  wire logic [pssl_pkg::CSR_ADDR_WIDTH-1:0]        csr_addr,
   input  wire logic [pssl_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata
);

`include "pid_speed_slew_limiter_assert.svh"

   localparam int GW    = pssl_pkg::GAIN_WIDTH;
   localparam int LW    = pssl_pkg::LIMIT_WIDTH;
   localparam int VW    = pssl_pkg::VEL_WIDTH;
   localparam int ERR_W = DATA_WIDTH - 1;
   localparam int MUL_W = (DATA_WIDTH + 1 > GW) ? DATA_WIDTH + 1 : GW;
   localparam int SQ_W  = 2 * DATA_WIDTH + 1;
   localparam int PID_W = GW + SUM_WIDTH + 2;
   localparam int ACC_W = (SQ_W > PID_W) ? SQ_W : PID_W;
   localparam int T_W   = ACC_W - FRAC_BITS;

   localparam logic [GW-1:0] KP_RESET    = GW'(1) << FRAC_BITS;
   localparam logic [LW-1:0] LIMIT_RESET = LW'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_SUM,
      ST_P,
      ST_D,
      ST_I,
      ST_SLEW,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      OP_X,
      OP_Y,
      OP_P,
      OP_D,
      OP_I
   } mac_op_type;

   // Configuration registers
   logic signed [GW-1:0] kp_ff;
   logic signed [GW-1:0] ki_ff;
   logic signed [GW-1:0] kd_ff;
   logic [LW-1:0]        speed_limit_ff;
   logic [LW-1:0]        accel_step_ff;

   // Sequencer and tick state
   ctrl_state_type              state_ff;
   mac_op_type                  op_ff;
   pssl_pkg::mac_ctrl_type      mac_ctrl_ff;
   logic                        sqrt_start_ff;
   logic                        slew_start_ff;
   logic                        rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] rsp_velocity_ff;
   logic [DATA_WIDTH-1:0]       dx_ff;
   logic [DATA_WIDTH-1:0]       dy_ff;
   logic [ERR_W-1:0]            err_ff;
   logic [ERR_W-1:0]            last_error_ff;
   logic signed [DATA_WIDTH-1:0] diff_ff;
   logic [SUM_WIDTH-2:0]        error_sum_ff;

   // Datapath wires
   logic [DATA_WIDTH-1:0]       ax;
   logic [DATA_WIDTH-1:0]       ay;
   logic signed [ACC_W-1:0]     mac_mcand;
   logic signed [MUL_W-1:0]     mac_mult;
   pssl_pkg::mac_stat_type      mac_stat;
   logic signed [ACC_W-1:0]     mac_acc;
   logic                        sqrt_busy;
   logic                        sqrt_done;
   logic [DATA_WIDTH-1:0]       sqrt_root;
   logic [ERR_W-1:0]            err_in;
   logic [SUM_WIDTH-1:0]        sum_n;
   logic [SUM_WIDTH-2:0]        error_sum_in;
   logic signed [DATA_WIDTH-1:0] diff_in;
   logic signed [T_W-1:0]       total;
   logic                        slew_done;
   logic signed [VW-1:0]        slew_velocity;
   logic                        in_xfer;
   logic                        out_free;
   pssl_pkg::mac_ctrl_type      mac_ctrl_in;
   logic                        sqrt_start_in;
   logic                        slew_start_in;
   logic                        rsp_valid_in;

   assign req_ready    = (state_ff == ST_IDLE);
   assign in_xfer      = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_velocity = rsp_velocity_ff;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff          <= KP_RESET;
         ki_ff          <= '0;
         kd_ff          <= '0;
         speed_limit_ff <= LIMIT_RESET;
         accel_step_ff  <= pssl_pkg::ACCEL_STEP_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            pssl_pkg::CSR_KP_GAIN:       kp_ff          <= csr_wdata[GW-1:0];
            pssl_pkg::CSR_KI_TIMES_STEP: ki_ff          <= csr_wdata[GW-1:0];
            pssl_pkg::CSR_KD_OVER_STEP:  kd_ff          <= csr_wdata[GW-1:0];
            pssl_pkg::CSR_SPEED_LIMIT:   speed_limit_ff <= csr_wdata[LW-1:0];
            pssl_pkg::CSR_ACCEL_STEP:    accel_step_ff  <= csr_wdata[LW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Magnitudes of the offsets
   assign ax = dx_ff[DATA_WIDTH-1] ? (~dx_ff + 1'b1) : dx_ff;
   assign ay = dy_ff[DATA_WIDTH-1] ? (~dy_ff + 1'b1) : dy_ff;

   // Select operands for the serial multiplier
   always_comb begin
      case (op_ff)
         OP_X: begin
            mac_mcand = ACC_W'(ax);
            mac_mult  = MUL_W'(ax);
         end
         OP_Y: begin
            mac_mcand = ACC_W'(ay);
            mac_mult  = MUL_W'(ay);
         end
         OP_P: begin
            mac_mcand = ACC_W'(err_ff);
            mac_mult  = MUL_W'(kp_ff);
         end
         OP_D: begin
            mac_mcand = ACC_W'(diff_ff);
            mac_mult  = MUL_W'(kd_ff);
         end
         OP_I: begin
            mac_mcand = ACC_W'(error_sum_ff);
            mac_mult  = MUL_W'(ki_ff);
         end
         default: begin
            mac_mcand = '0;
            mac_mult  = '0;
         end
      endcase
   end

   // Saturate the root, accumulate the error sum, form the difference
   assign err_in       = sqrt_root[DATA_WIDTH-1] ? {ERR_W{1'b1}} : sqrt_root[ERR_W-1:0];
   assign sum_n        = {1'b0, error_sum_ff} + SUM_WIDTH'(err_ff);
   assign error_sum_in = sum_n[SUM_WIDTH-1] ? {(SUM_WIDTH-1){1'b1}} : sum_n[SUM_WIDTH-2:0];
   assign diff_in      = $signed({1'b0, last_error_ff}) - $signed({1'b0, err_ff});

   // Floor the accumulated PID sum to the output scale
   assign total = mac_acc[ACC_W-1:FRAC_BITS];

   pssl_mac #(
      .ACC_W (ACC_W),
      .MUL_W (MUL_W)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl_ff),
      .mcand (mac_mcand),
      .mult  (mac_mult),
      .stat  (mac_stat),
      .acc   (mac_acc)
   );

   pssl_isqrt #(
      .DW (DATA_WIDTH)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand (mac_acc[2*DATA_WIDTH-1:0]),
      .busy     (sqrt_busy),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   pssl_slew #(
      .T_W (T_W)
   ) u_slew (
      .clock       (clock),
      .reset       (reset),
      .start       (slew_start_ff),
      .total       (total),
      .speed_limit (speed_limit_ff),
      .accel_step  (accel_step_ff),
      .done        (slew_done),
      .velocity    (slew_velocity)
   );

   // Decode unit start pulses and the result valid for the next cycle
   always_comb begin
      mac_ctrl_in   = '0;
      sqrt_start_in = 1'b0;
      slew_start_in = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               mac_ctrl_in.start = 1'b1;
               mac_ctrl_in.clear = 1'b1;
            end
         end
         ST_SQX, ST_P, ST_D: begin
            mac_ctrl_in.start = mac_stat.done;
         end
         ST_SQY: begin
            sqrt_start_in = mac_stat.done;
         end
         ST_SUM: begin
            mac_ctrl_in.start = 1'b1;
            mac_ctrl_in.clear = 1'b1;
         end
         ST_I: begin
            slew_start_in = mac_stat.done;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Sequence one tick and hold the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_X;
         mac_ctrl_ff   <= '0;
         sqrt_start_ff <= 1'b0;
         slew_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else begin
         mac_ctrl_ff   <= mac_ctrl_in;
         sqrt_start_ff <= sqrt_start_in;
         slew_start_ff <= slew_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (in_xfer) begin
                  dx_ff    <= req_offset_x;
                  dy_ff    <= req_offset_y;
                  op_ff    <= OP_X;
                  state_ff <= ST_SQX;
               end
            end
            ST_SQX: begin
               if (mac_stat.done) begin
                  op_ff    <= OP_Y;
                  state_ff <= ST_SQY;
               end
            end
            ST_SQY: begin
               if (mac_stat.done) begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (sqrt_done) begin
                  err_ff   <= err_in;
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               error_sum_ff  <= error_sum_in;
               diff_ff       <= diff_in;
               last_error_ff <= err_ff;
               op_ff         <= OP_P;
               state_ff      <= ST_P;
            end
            ST_P: begin
               if (mac_stat.done) begin
                  op_ff    <= OP_D;
                  state_ff <= ST_D;
               end
            end
            ST_D: begin
               if (mac_stat.done) begin
                  op_ff    <= OP_I;
                  state_ff <= ST_I;
               end
            end
            ST_I: begin
               if (mac_stat.done) begin
                  state_ff <= ST_SLEW;
               end
            end
            ST_SLEW: begin
               if (slew_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_velocity_ff <= DATA_WIDTH'(slew_velocity);
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // One tick in flight at a time
   `ASSERT_NEXT(a_one_tick, clock, reset, in_xfer, !req_ready, "input taken while busy")
   // Multiplier and root unit never run together
   `ASSERT_IMPL(a_unit_excl, clock, reset, mac_stat.busy, !sqrt_busy, "multiplier and root overlap")
   // Slew result arrives only while the sequencer waits for it
   `ASSERT_IMPL(a_slew_done, clock, reset, slew_done, state_ff == ST_SLEW, "stray slew result")

endmodule
`default_nettype wire

### design/pssl_mac.sv
// Bit-serial multiply-accumulate unit: one multiplier bit per cycle.
`default_nettype none
module pssl_mac #(
   parameter int ACC_W = 73,
   parameter int MUL_W = 33
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pssl_pkg::mac_ctrl_type    ctrl,
   input  wire logic signed [ACC_W-1:0]   mcand,
   input  wire logic signed [MUL_W-1:0]   mult,
   output      pssl_pkg::mac_stat_type    stat,
   output      logic signed [ACC_W-1:0]   acc
);

   localparam int CNT_W = (MUL_W > 1) ? $clog2(MUL_W) : 1;

   logic                    busy_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic [ACC_W-1:0]        mcand_ff;
   logic [MUL_W-1:0]        mult_ff;
   logic [ACC_W-1:0]        term;
   logic                    last;

   // Top multiplier bit carries negative weight
   assign last   = (cnt_ff == CNT_W'(MUL_W - 1));
   assign term   = mult_ff[0] ? mcand_ff : '0;
   assign acc_in = last ? (acc_ff - $signed(term)) : (acc_ff + $signed(term));

   // Sequence the bit count
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctrl.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Load operands, then shift and accumulate
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         mcand_ff <= mcand;
         mult_ff  <= mult;
         if (ctrl.clear) begin
            acc_ff <= '0;
         end
      end else if (busy_ff) begin
         acc_ff   <= acc_in;
         mcand_ff <= mcand_ff << 1;
         mult_ff  <= mult_ff >> 1;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && last;
   assign acc       = acc_ff;

endmodule
`default_nettype wire

### design/pssl_isqrt.sv
// Digit-serial floor square root: two radicand bits per cycle.
`default_nettype none
module pssl_isqrt #(
   parameter int DW = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [2*DW-1:0]   radicand,
   output      logic              busy,
   output      logic              done,
   output      logic [DW-1:0]     root
);

   localparam int CNT_W = $clog2(DW);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [2*DW-1:0]   rad_ff;
   logic [DW+1:0]     rem_ff;
   logic [DW-1:0]     root_ff;
   logic [DW+3:0]     rem_n;
   logic [DW+3:0]     trial;
   logic [DW+3:0]     sub;
   logic              ge;
   logic              last;

   // Bring down the next digit and try the next root bit
   assign rem_n = {rem_ff, rad_ff[2*DW-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign sub   = rem_n - trial;
   assign ge    = (rem_n >= trial);
   assign last  = (cnt_ff == CNT_W'(DW - 1));

   // Sequence the digit count; flag done once the last root bit is in
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Shift the radicand and update remainder and root
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= ge ? sub[DW+1:0] : rem_n[DW+1:0];
         root_ff <= {root_ff[DW-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

### design/pssl_slew.sv
// Speed cap, slew clamp and final limit; holds the previous velocity.
`default_nettype none
module pssl_slew #(
   parameter int T_W = 57
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire logic signed [T_W-1:0]                    total,
   input  wire logic [pssl_pkg::LIMIT_WIDTH-1:0]         speed_limit,
   input  wire logic [pssl_pkg::LIMIT_WIDTH-1:0]         accel_step,
   output      logic                                     done,
   output      logic signed [pssl_pkg::VEL_WIDTH-1:0]    velocity
);

   localparam int VW = pssl_pkg::VEL_WIDTH;

   typedef enum logic [1:0] {
      SL_IDLE,
      SL_CAP,
      SL_STEP,
      SL_CLAMP
   } slew_state_type;

   slew_state_type        state_ff;
   logic                  done_ff;
   logic signed [VW-1:0]  last_vel_ff;
   logic signed [T_W-1:0] cmd_ff;
   logic signed [VW-1:0]  delta_ff;

   logic signed [T_W-1:0] lim_t;
   logic signed [T_W-1:0] cmd_in;
   logic signed [T_W:0]   diff;
   logic signed [T_W:0]   acc_t;
   logic signed [VW-1:0]  delta_in;
   logic signed [VW:0]    vsum;
   logic signed [VW:0]    lim_v;
   logic signed [VW-1:0]  vel_in;

   // Cap the command from above only
   always_comb begin
      lim_t  = T_W'($signed({1'b0, speed_limit}));
      cmd_in = (total > lim_t) ? lim_t : total;
   end

   // Clamp the change against the previous velocity
   always_comb begin
      diff  = (T_W+1)'(cmd_ff) - (T_W+1)'(last_vel_ff);
      acc_t = (T_W+1)'($signed({1'b0, accel_step}));
      if (diff > acc_t) begin
         delta_in = VW'(acc_t);
      end else if (diff < -acc_t) begin
         delta_in = VW'(-acc_t);
      end else begin
         delta_in = VW'(diff);
      end
   end

   // Clamp the new velocity to the speed limit
   always_comb begin
      vsum  = (VW+1)'(last_vel_ff) + (VW+1)'(delta_ff);
      lim_v = (VW+1)'($signed({1'b0, speed_limit}));
      if (vsum > lim_v) begin
         vel_in = VW'(lim_v);
      end else if (vsum < -lim_v) begin
         vel_in = VW'(-lim_v);
      end else begin
         vel_in = VW'(vsum);
      end
   end

   // Step through cap, slew and clamp
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SL_IDLE;
         done_ff     <= 1'b0;
         last_vel_ff <= '0;
      end else begin
         done_ff <= (state_ff == SL_CLAMP);
         case (state_ff)
            SL_IDLE: begin
               if (start) begin
                  state_ff <= SL_CAP;
               end
            end
            SL_CAP: begin
               cmd_ff   <= cmd_in;
               state_ff <= SL_STEP;
            end
            SL_STEP: begin
               delta_ff <= delta_in;
               state_ff <= SL_CLAMP;
            end
            SL_CLAMP: begin
               last_vel_ff <= vel_in;
               state_ff    <= SL_IDLE;
            end
            default: begin
               state_ff <= SL_IDLE;
            end
         endcase
      end
   end

   assign done     = done_ff;
   assign velocity = last_vel_ff;

endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the PID speed controller with slew-rate limit.
`default_nettype none
module tb;

   localparam int GAIN_WIDTH = pssl_pkg::GAIN_WIDTH;
   localparam int LIMIT_WIDTH = pssl_pkg::LIMIT_WIDTH;
   localparam int CSR_ADDR_WIDTH = pssl_pkg::CSR_ADDR_WIDTH;
   localparam int CSR_DATA_WIDTH = pssl_pkg::CSR_DATA_WIDTH;
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int SUM_W = 48;
   localparam int RANDOM_ITEMS = 1430;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int END_CYCLES = 300;
   localparam logic [63:0] ERR_MAX = 64'h7FFF_FFFF;
   localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF;
   localparam longint BIG_CAP = longint'(1) << 46;
   localparam logic signed [DATA_W-1:0] OFFSET_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] OFFSET_MIN = 32'sh8000_0000;
   localparam logic signed [GAIN_WIDTH-1:0] GAIN_MAX = 24'sh7F_FFFF;
   localparam logic signed [GAIN_WIDTH-1:0] GAIN_MIN = 24'sh80_0000;
   localparam logic signed [GAIN_WIDTH-1:0] GAIN_ONE = 24'sh01_0000;
   localparam logic [LIMIT_WIDTH-1:0] BOUND_MAX = 31'h7FFF_FFFF;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [DATA_W-1:0] req_offset_x;
   logic signed [DATA_W-1:0] req_offset_y;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [DATA_W-1:0] rsp_velocity;
   logic csr_wr_en;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   // Shadow copy of the controller registers and state
   logic signed [GAIN_WIDTH-1:0] kp_q, ki_q, kd_q;
   logic [LIMIT_WIDTH-1:0] limit_q, accel_q;
   logic [SUM_W-1:0] err_sum_q;
   logic signed [DATA_W-1:0] last_err_q, last_vel_q;

   logic signed [DATA_W-1:0] velocity_due[$];
   logic signed [DATA_W-1:0] want_velocity;
   bit tx_idle_on, rx_idle_on;
   int hold_cycles, idle_cycles;
   int fail_count, offsets_sent, velocities_checked, csr_writes, random_phases;

   pid_speed_slew_limiter u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_offset_x (req_offset_x),
      .req_offset_y (req_offset_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_velocity (rsp_velocity),
      .csr_wr_en    (csr_wr_en),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      if (r < 98) return $urandom_range(5, 40);
      return $urandom_range(100, 400);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_offset();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: begin
            case ($urandom_range(0, 4))
               0: return OFFSET_MAX;
               1: return OFFSET_MIN;
               2: return 32'sd1;
               3: return -32'sd1;
               default: return 32'sd0;
            endcase
         end
         2, 3, 4: return int'($urandom_range(0, 2097152)) - 1048576;
         5, 6: return int'($urandom_range(0, 134217728)) - 67108864;
         default: return int'($urandom_range(0, 262144)) - 131072;
      endcase
   endfunction

   function automatic logic signed [GAIN_WIDTH-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return GAIN_MAX;
         1: return GAIN_MIN;
         2: return '0;
         3, 4: return GAIN_WIDTH'($urandom());
         default: return GAIN_WIDTH'(int'($urandom_range(0, 196608)) - 65536);
      endcase
   endfunction

   // Speed limit or acceleration step; span_log sets the typical magnitude
   function automatic logic [LIMIT_WIDTH-1:0] pick_bound(input int span_log);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return BOUND_MAX;
         2, 3: return LIMIT_WIDTH'($urandom_range(0, 1 << span_log));
         4, 5: return LIMIT_WIDTH'($urandom_range(0, 1 << (span_log + 6)));
         default: return LIMIT_WIDTH'($urandom());
      endcase
   endfunction

   // Advance the shadow controller by one tick and queue the velocity it yields
   task automatic advance_controller(input logic signed [DATA_W-1:0] dx,
                                     input logic signed [DATA_W-1:0] dy);
      logic [63:0] ax, ay, rem, root, bit_w, new_sum;
      longint e, lo_part, hi_part, acc, big, total, lim, slew, cmd, step, vel;
      ax = (dx < 0) ? -longint'(dx) : longint'(dx);
      ay = (dy < 0) ? -longint'(dy) : longint'(dy);
      rem = ax * ax + ay * ay;
      // floor square root, two bits per pass
      root = '0;
      bit_w = 64'h4000_0000_0000_0000;
      while (bit_w > rem) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (rem >= root + bit_w) begin
            rem = rem - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      if (root > ERR_MAX) root = ERR_MAX;
      e = longint'(root);
      new_sum = {16'd0, err_sum_q} + root;
      if (new_sum > SUM_MAX) new_sum = SUM_MAX;
      err_sum_q = new_sum[SUM_W-1:0];
      lo_part = longint'({40'd0, err_sum_q[23:0]});
      hi_part = longint'({40'd0, err_sum_q[47:24]});
      // PID sum, exact, floored once to the output format
      acc = kp_q * e + kd_q * (last_err_q - e) + ki_q * lo_part;
      big = ki_q * hi_part;
      if (big > BIG_CAP) big = BIG_CAP;
      if (big < -BIG_CAP) big = -BIG_CAP;
      total = big * 256 + (acc >>> FRAC_W);
      last_err_q = e[DATA_W-1:0];
      // upper cap, slew clamp, then symmetric speed clamp
      lim = longint'({33'd0, limit_q});
      slew = longint'({33'd0, accel_q});
      cmd = (total > lim) ? lim : total;
      step = cmd - last_vel_q;
      if (step > slew) step = slew;
      if (step < -slew) step = -slew;
      vel = last_vel_q + step;
      if (vel > lim) vel = lim;
      if (vel < -lim) vel = -lim;
      last_vel_q = vel[DATA_W-1:0];
      velocity_due.push_back(vel[DATA_W-1:0]);
   endtask

   // Present one offset and hold it until the transfer
   task automatic send_offset(input logic signed [DATA_W-1:0] dx,
                              input logic signed [DATA_W-1:0] dy);
      int gap;
      gap = tx_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_offset_x <= dx;
      req_offset_y <= dy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_controller(dx, dy);
      offsets_sent++;
   endtask

   // Drop valid and wait until every velocity has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (velocity_due.size() != 0) @(posedge clock);
   endtask

   // Register write, only while idle
   task automatic write_reg(input logic [CSR_ADDR_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         pssl_pkg::CSR_KP_GAIN:       kp_q = value[GAIN_WIDTH-1:0];
         pssl_pkg::CSR_KI_TIMES_STEP: ki_q = value[GAIN_WIDTH-1:0];
         pssl_pkg::CSR_KD_OVER_STEP:  kd_q = value[GAIN_WIDTH-1:0];
         pssl_pkg::CSR_SPEED_LIMIT:   limit_q = value[LIMIT_WIDTH-1:0];
         pssl_pkg::CSR_ACCEL_STEP:    accel_q = value[LIMIT_WIDTH-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic write_gains(input logic signed [GAIN_WIDTH-1:0] kp,
                              input logic signed [GAIN_WIDTH-1:0] ki,
                              input logic signed [GAIN_WIDTH-1:0] kd);
      write_reg(pssl_pkg::CSR_KP_GAIN, CSR_DATA_WIDTH'(kp));
      write_reg(pssl_pkg::CSR_KI_TIMES_STEP, CSR_DATA_WIDTH'(ki));
      write_reg(pssl_pkg::CSR_KD_OVER_STEP, CSR_DATA_WIDTH'(kd));
   endtask

   // Reset values: unit gain, unit limit, small slew step
   task automatic test_reset_defaults();
      send_offset(32'sd0, 32'sd0);
      send_offset(OFFSET_MAX, OFFSET_MAX);
      send_offset(OFFSET_MIN, OFFSET_MIN);
      send_offset(OFFSET_MIN, OFFSET_MAX);
      send_offset(32'sd1, -32'sd1);
      send_offset(32'sh0001_0000, 32'sd0);
      drain_results();
   endtask

   // Zero speed limit forces zero; zero slew step holds the last velocity
   task automatic test_zero_limits();
      write_reg(pssl_pkg::CSR_SPEED_LIMIT, '0);
      send_offset(32'sh0004_0000, 32'sh0003_0000);
      send_offset(-32'sh0010_0000, 32'sd7);
      drain_results();
      write_reg(pssl_pkg::CSR_SPEED_LIMIT, 31'h0001_0000);
      write_reg(pssl_pkg::CSR_ACCEL_STEP, 31'h0000_4000);
      send_offset(32'sh0002_0000, 32'sd0);
      drain_results();
      write_reg(pssl_pkg::CSR_ACCEL_STEP, '0);
      send_offset(32'sh0000_8000, -32'sh0000_8000);
      send_offset(32'sd0, 32'sd0);
      drain_results();
   endtask

   // Lowering the limit below the last velocity pulls the output back in
   task automatic test_limit_lowered();
      write_gains(GAIN_MAX, '0, '0);
      write_reg(pssl_pkg::CSR_SPEED_LIMIT, BOUND_MAX);
      write_reg(pssl_pkg::CSR_ACCEL_STEP, BOUND_MAX);
      send_offset(32'sh0001_0000, 32'sd0);
      drain_results();
      write_reg(pssl_pkg::CSR_SPEED_LIMIT, 31'd1000);
      write_reg(pssl_pkg::CSR_ACCEL_STEP, '0);
      send_offset(32'sh0001_0000, 32'sd0);
      drain_results();
      write_reg(pssl_pkg::CSR_ACCEL_STEP, BOUND_MAX);
      send_offset(32'sd0, 32'sd0);
      drain_results();
   endtask

   // Negative gains: large negative commands pass the upper cap
   task automatic test_negative_gains();
      write_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN);
      write_reg(pssl_pkg::CSR_SPEED_LIMIT, BOUND_MAX);
      send_offset(32'sh0001_0000, 32'sh0001_0000);
      send_offset(OFFSET_MAX, OFFSET_MIN);
      drain_results();
      write_gains(GAIN_ONE, GAIN_MAX, GAIN_MAX);
      send_offset(32'sd0, 32'sd0);
      send_offset(-32'sh0000_0100, 32'sh0000_0200);
      drain_results();
      write_gains(-GAIN_ONE, '0, GAIN_MIN);
      send_offset(32'sh0000_0001, 32'sd0);
      drain_results();
   endtask

   // Random settings per phase; steady approach runs or independent offsets
   task automatic test_random_phases();
      int count, n;
      bit approach;
      logic signed [DATA_W-1:0] px, py;
      count = 0;
      px = '0;
      py = '0;
      while (count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            write_reg(pssl_pkg::CSR_KP_GAIN, CSR_DATA_WIDTH'(pick_gain()));
         end
         if ($urandom_range(0, 9) < 7) begin
            write_reg(pssl_pkg::CSR_KI_TIMES_STEP, CSR_DATA_WIDTH'(pick_gain()));
         end
         if ($urandom_range(0, 9) < 7) begin
            write_reg(pssl_pkg::CSR_KD_OVER_STEP, CSR_DATA_WIDTH'(pick_gain()));
         end
         if ($urandom_range(0, 9) < 7) begin
            write_reg(pssl_pkg::CSR_SPEED_LIMIT, pick_bound(18));
         end
         if ($urandom_range(0, 9) < 7) begin
            write_reg(pssl_pkg::CSR_ACCEL_STEP, pick_bound(12));
         end
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         approach = ($urandom_range(0, 9) < 6);
         n = $urandom_range(25, 75);
         for (int i = 0; i < n; i++) begin
            if (!approach || (i % 12 == 0)) begin
               px = pick_offset();
               py = pick_offset();
            end else begin
               // close in on the target with a little jitter
               px = px - (px >>> 3) + (int'($urandom_range(0, 64)) - 32);
               py = py - (py >>> 3) + (int'($urandom_range(0, 64)) - 32);
            end
            send_offset(px, py);
         end
         count += n;
         drain_results();
         random_phases++;
      end
   endtask

   // Receiver stalls
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each velocity transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (velocity_due.size() == 0) begin
            $error("velocity transfer with nothing expected: actual %0d", rsp_velocity);
            fail_count++;
         end else begin
            want_velocity = velocity_due.pop_front();
            if (rsp_velocity !== want_velocity) begin
               $error("velocity mismatch: expected %0d, actual %0d",
                      want_velocity, rsp_velocity);
               fail_count++;
            end
            velocities_checked++;
         end
      end
   end

   // Abort when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_offset_x = '0;
      req_offset_y = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      hold_cycles = 0;
      idle_cycles = 0;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      kp_q = GAIN_ONE;
      ki_q = '0;
      kd_q = '0;
      limit_q = 31'h0001_0000;
      accel_q = pssl_pkg::ACCEL_STEP_RESET;
      err_sum_q = '0;
      last_err_q = '0;
      last_vel_q = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_limits();
      test_limit_lowered();
      test_negative_gains();
      test_random_phases();

      drain_results();
      repeat (END_CYCLES) @(posedge clock);
      if (velocity_due.size() != 0) begin
         $error("%0d velocities never arrived", velocity_due.size());
         fail_count++;
      end
      $display("%0d offsets sent, %0d velocities checked, %0d register writes",
               offsets_sent, velocities_checked, csr_writes);
      $display("default, zero-limit, lowered-limit and negative-gain cases, %0d random phases",
               random_phases);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
